### rtl/core/encoder_synced_move_profile_top_macros.svh
// Assertion macros used by the checker file.
`ifndef ENCODER_SYNCED_MOVE_PROFILE_TOP_MACROS_SVH
`define ENCODER_SYNCED_MOVE_PROFILE_TOP_MACROS_SVH

// Overlapping implication under reset.
`define ESMP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("esmp check failed");

// Next-cycle implication under reset.
`define ESMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("esmp check failed");

`endif

### rtl/core/esmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esmp_pkg
// Payload types and fixed codes of the synced move profile block.
// ----------------------------------------------------------------------------
package esmp_pkg;

    typedef struct packed {
        logic        kind;
        logic [15:0] distance;
        logic        left_pulse;
        logic        right_pulse;
    } t_in_item;

    typedef struct packed {
        logic [9:0] left_duty;
        logic [9:0] right_duty;
        logic [1:0] led_color;
        logic       moving;
        logic       finished;
    } t_out_item;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_PULSE = 1'b1;

    localparam logic [1:0] LED_GREEN = 2'd0;
    localparam logic [1:0] LED_RED   = 2'd1;
    localparam logic [1:0] LED_BLUE  = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_RAMP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_RAMP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_INT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CORR_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_INC   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_MIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_SCALE = 3'd6;

    localparam int PERMILLE = 1000;

endpackage

### rtl/core/esmp_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esmp_muldiv
// Bit-serial (a*b)/c: shift-add multiply, then restoring divide, one bit a cycle.
// ----------------------------------------------------------------------------
module esmp_muldiv #(
    parameter int AW = 16,
    parameter int MW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [AW-1:0]     i_a,
    input  logic [MW-1:0]     i_b,
    input  logic [AW-1:0]     i_c,
    output logic              o_done,
    output logic [AW+MW-1:0]  o_quo
);
    localparam int PW = AW + MW;
    localparam int NW = $clog2(PW);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]    r_ph;
    logic [NW-1:0] r_cnt;
    logic [PW-1:0] r_acc;
    logic [PW-1:0] r_ash;
    logic [MW-1:0] r_bsh;
    logic [AW-1:0] r_c;
    logic [AW-1:0] r_rem;
    logic          r_done;

    logic [AW:0]   c_rsh;
    logic [AW:0]   c_sub;

    assign c_rsh = {r_rem, r_acc[PW-1]};
    assign c_sub = c_rsh - {1'b0, r_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_ph)
                PH_IDLE: begin
                    if (i_start) begin
                        r_acc <= '0;
                        r_ash <= PW'(i_a);
                        r_bsh <= i_b;
                        r_c   <= i_c;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_ph  <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    // accumulate one multiplier bit
                    if (r_bsh[0]) begin
                        r_acc <= r_acc + r_ash;
                    end
                    r_ash <= {r_ash[PW-2:0], 1'b0};
                    r_bsh <= r_bsh >> 1;
                    if (r_cnt == NW'(MW - 1)) begin
                        r_cnt <= '0;
                        r_ph  <= PH_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                PH_DIV: begin
                    // one quotient bit per cycle
                    if (!c_sub[AW]) begin
                        r_rem <= c_sub[AW-1:0];
                        r_acc <= {r_acc[PW-2:0], 1'b1};
                    end else begin
                        r_rem <= c_rsh[AW-1:0];
                        r_acc <= {r_acc[PW-2:0], 1'b0};
                    end
                    if (r_cnt == NW'(PW - 1)) begin
                        r_ph   <= PH_IDLE;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_acc;

endmodule

### rtl/core/encoder_synced_move_profile_top.sv
`timescale 1ns / 1ps
// Two-wheel move controller. A start item loads the targets and speed terms, pulse
// items count encoder ticks, rebalance the wheels once either wheel is more than
// sync_interval ticks past its last mark and return fresh PWM duties. All products
// and quotients go through one bit-serial multiply-divide unit. Each use holds the
// sequencer for the multiply steps, the divide steps and the hand-over. A start
// item uses it up to three times. A pulse item uses it up to four times, with the
// check, balance, finish and output steps around them. Both use it fewer times when
// no balance check or no ramp applies. An idle pulse goes straight to the output
// step. The input is ready again when each result is registered. One item is in
// work at a time; its result waits in the output register while the next item is
// taken.
// ----------------------------------------------------------------------------
// encoder_synced_move_profile_top
// Sequencer, state and output register of the synced move profile block.
// ----------------------------------------------------------------------------
module encoder_synced_move_profile_top #(
    parameter int COUNT_WIDTH = 16,
    parameter int DUTY_PERIOD = 1000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  esmp_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output esmp_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_we,
    input  logic [esmp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [esmp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import esmp_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int DW = $clog2(DUTY_PERIOD + 1);
    localparam int AW = (CW > 16) ? CW : 16;
    localparam int MW = (DW > 10) ? DW : 10;
    localparam int PW = AW + MW;
    localparam int TW = MW + 1;
    localparam logic [AW-1:0] CMAX = AW'({CW{1'b1}});
    localparam logic [PW:0]   DUTY_P = (PW + 1)'(DUTY_PERIOD);
    localparam logic [TW-1:0] DUTY_T = TW'(DUTY_PERIOD);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LT   = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_SHR  = 4'd3;
    localparam logic [3:0] S_SHL  = 4'd4;
    localparam logic [3:0] S_BAL  = 4'd5;
    localparam logic [3:0] S_DRR  = 4'd6;
    localparam logic [3:0] S_DRL  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    // configuration
    logic [15:0] r_fast, r_slow, r_sync;
    logic [7:0]  r_step;
    logic [9:0]  r_init_inc, r_init_min, r_scale;

    // move state
    logic [3:0]    r_state;
    logic          r_launch;
    t_in_item      r_in;
    logic [CW-1:0] r_rc, r_lc, r_rm, r_lm, r_rt, r_lt;
    logic [DW-1:0] r_rs, r_rf, r_ls, r_lf, r_rd, r_ld;
    logic [PW-1:0] r_sr, r_sl;
    logic [1:0]    r_ind;
    logic          r_active, r_moving, r_fin;
    t_out_item     r_out;
    logic          r_out_valid;

    // serial unit interface
    logic          c_start, c_need, u_done;
    logic [AW-1:0] c_a, c_c;
    logic [MW-1:0] c_b;
    logic [PW-1:0] u_quo;

    // per-wheel view for the drive steps
    logic [AW-1:0] w_cnt, w_tgt, w_rem;
    logic [DW-1:0] w_span, w_floor;
    logic          w_ge, w_fast, w_slow;
    logic [PW:0]   w_sum;
    logic [DW-1:0] w_duty;
    logic [AW-1:0] c_fast1, c_slow1;

    logic [AW-1:0] c_rd, c_ld;
    logic          c_trig;
    logic [PW-1:0] c_lt_q;

    logic [MW-1:0] c_init_inc_m, c_init_min_m;
    logic [DW-1:0] c_init_inc, c_init_min;
    logic [TW-1:0] c_rs_up, c_rf_up, c_ls_up, c_lf_up;
    logic [DW-1:0] c_rs_up_c, c_rf_up_c, c_ls_up_c, c_lf_up_c;
    logic [DW-1:0] c_rs_dn, c_rf_dn, c_ls_dn, c_lf_dn;
    logic [DW-1:0] c_step_d;

    esmp_muldiv #(.AW(AW), .MW(MW)) u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_a     (c_a),
        .i_b     (c_b),
        .i_c     (c_c),
        .o_done  (u_done),
        .o_quo   (u_quo)
    );

    // ramp lengths of zero count as one
    assign c_fast1 = (r_fast == 16'd0) ? AW'(1) : AW'(r_fast);
    assign c_slow1 = (r_slow == 16'd0) ? AW'(1) : AW'(r_slow);

    // select the wheel being driven
    always_comb begin
        if (r_state == S_DRR) begin
            w_cnt   = AW'(r_rc);
            w_tgt   = AW'(r_rt);
            w_span  = r_rs;
            w_floor = r_rf;
        end else begin
            w_cnt   = AW'(r_lc);
            w_tgt   = AW'(r_lt);
            w_span  = r_ls;
            w_floor = r_lf;
        end
    end

    assign w_rem  = w_tgt - w_cnt;
    assign w_ge   = (w_cnt >= w_tgt);
    assign w_fast = (w_cnt <= AW'(r_fast));
    assign w_slow = (w_rem <= AW'(r_slow));
    assign w_sum  = (PW + 1)'(w_floor) + (PW + 1)'(u_quo);
    assign w_duty = (w_sum > DUTY_P) ? DW'(DUTY_PERIOD) : DW'(w_sum);

    assign c_rd   = AW'(r_rc - r_rm);
    assign c_ld   = AW'(r_lc - r_lm);
    assign c_trig = (c_rd > AW'(r_sync)) || (c_ld > AW'(r_sync));
    assign c_lt_q = u_quo;

    // operands of the serial unit for each step
    always_comb begin
        c_need = 1'b0;
        c_a    = '0;
        c_b    = '0;
        c_c    = AW'(1);
        case (r_state)
            S_LT: begin
                c_need = 1'b1;
                c_a    = AW'(r_in.distance);
                c_b    = MW'(r_scale);
                c_c    = AW'(PERMILLE);
            end
            S_SHR: begin
                c_need = (r_rt != '0);
                c_a    = c_rd;
                c_b    = MW'(PERMILLE);
                c_c    = AW'(r_rt);
            end
            S_SHL: begin
                c_need = (r_lt != '0);
                c_a    = c_ld;
                c_b    = MW'(PERMILLE);
                c_c    = AW'(r_lt);
            end
            S_DRR, S_DRL: begin
                c_b = MW'(w_span);
                if (!w_ge && w_fast) begin
                    c_need = 1'b1;
                    c_a    = w_cnt;
                    c_c    = c_fast1;
                end else if (!w_ge && w_slow) begin
                    c_need = 1'b1;
                    c_a    = w_rem;
                    c_c    = c_slow1;
                end
            end
            default: c_need = 1'b0;
        endcase
    end

    assign c_start = c_need && !r_launch;

    // initial terms clamped to the duty period
    assign c_init_inc_m = MW'(r_init_inc);
    assign c_init_min_m = MW'(r_init_min);
    assign c_init_inc   = (c_init_inc_m > MW'(DUTY_PERIOD)) ? DW'(DUTY_PERIOD)
                                                            : DW'(c_init_inc_m);
    assign c_init_min   = (c_init_min_m > MW'(DUTY_PERIOD)) ? DW'(DUTY_PERIOD)
                                                            : DW'(c_init_min_m);

    // saturating correction of the speed terms
    assign c_rs_up   = TW'(r_rs) + TW'(r_step);
    assign c_rf_up   = TW'(r_rf) + TW'(r_step);
    assign c_ls_up   = TW'(r_ls) + TW'(r_step);
    assign c_lf_up   = TW'(r_lf) + TW'(r_step);
    assign c_rs_up_c = (c_rs_up > DUTY_T) ? DW'(DUTY_PERIOD) : DW'(c_rs_up);
    assign c_rf_up_c = (c_rf_up > DUTY_T) ? DW'(DUTY_PERIOD) : DW'(c_rf_up);
    assign c_ls_up_c = (c_ls_up > DUTY_T) ? DW'(DUTY_PERIOD) : DW'(c_ls_up);
    assign c_lf_up_c = (c_lf_up > DUTY_T) ? DW'(DUTY_PERIOD) : DW'(c_lf_up);
    assign c_step_d  = DW'(r_step);
    assign c_rs_dn   = (TW'(r_rs) > TW'(r_step)) ? (r_rs - c_step_d) : '0;
    assign c_rf_dn   = (TW'(r_rf) > TW'(r_step)) ? (r_rf - c_step_d) : '0;
    assign c_ls_dn   = (TW'(r_ls) > TW'(r_step)) ? (r_ls - c_step_d) : '0;
    assign c_lf_dn   = (TW'(r_lf) > TW'(r_step)) ? (r_lf - c_step_d) : '0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast     <= 16'd200;
            r_slow     <= 16'd500;
            r_sync     <= 16'd50;
            r_step     <= 8'd5;
            r_init_inc <= 10'd500;
            r_init_min <= 10'd150;
            r_scale    <= 10'd998;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FAST_RAMP:  r_fast     <= i_cfg_wdata;
                REG_SLOW_RAMP:  r_slow     <= i_cfg_wdata;
                REG_SYNC_INT:   r_sync     <= i_cfg_wdata;
                REG_CORR_STEP:  r_step     <= i_cfg_wdata[7:0];
                REG_INIT_INC:   r_init_inc <= i_cfg_wdata[9:0];
                REG_INIT_MIN:   r_init_min <= i_cfg_wdata[9:0];
                REG_LEFT_SCALE: r_scale    <= i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_active    <= 1'b0;
            r_ind       <= LED_GREEN;
            r_rc        <= '0;
            r_lc        <= '0;
            r_rm        <= '0;
            r_lm        <= '0;
            r_rt        <= '0;
            r_lt        <= '0;
            r_rs        <= '0;
            r_rf        <= '0;
            r_ls        <= '0;
            r_lf        <= '0;
            r_rd        <= '0;
            r_ld        <= '0;
            r_moving    <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop valid once the result is taken, unless a new one is loaded
            if (o_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            if (c_start) begin
                r_launch <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in <= i_in;
                        if (i_in.kind == KIND_START) begin
                            r_state <= S_LT;
                        end else if (r_active) begin
                            // count ticks, saturating at the count maximum
                            if (i_in.left_pulse && (r_lc != CW'(CMAX))) begin
                                r_lc <= r_lc + 1'b1;
                            end
                            if (i_in.right_pulse && (r_rc != CW'(CMAX))) begin
                                r_rc <= r_rc + 1'b1;
                            end
                            r_state <= S_CHK;
                        end else begin
                            // idle pulse: report held state only
                            r_moving <= 1'b0;
                            r_fin    <= 1'b0;
                            r_state  <= S_OUT;
                        end
                    end
                end
                S_LT: begin
                    if (r_launch && u_done) begin
                        r_launch <= 1'b0;
                        r_rt     <= (AW'(r_in.distance) > CMAX) ? CW'(CMAX)
                                                              : CW'(r_in.distance);
                        r_lt     <= (c_lt_q > PW'(CMAX)) ? CW'(CMAX) : CW'(c_lt_q);
                        r_rc     <= '0;
                        r_lc     <= '0;
                        r_rm     <= '0;
                        r_lm     <= '0;
                        r_rs     <= c_init_inc;
                        r_ls     <= c_init_inc;
                        r_rf     <= c_init_min;
                        r_lf     <= c_init_min;
                        r_rd     <= '0;
                        r_ld     <= '0;
                        r_active <= 1'b1;
                        r_state  <= S_DRR;
                    end
                end
                S_CHK: begin
                    r_state <= c_trig ? S_SHR : S_DRR;
                end
                S_SHR: begin
                    if (!c_need) begin
                        r_sr    <= PW'(PERMILLE);
                        r_state <= S_SHL;
                    end else if (r_launch && u_done) begin
                        r_launch <= 1'b0;
                        r_sr     <= u_quo;
                        r_state  <= S_SHL;
                    end
                end
                S_SHL: begin
                    if (!c_need) begin
                        r_sl    <= PW'(PERMILLE);
                        r_state <= S_BAL;
                    end else if (r_launch && u_done) begin
                        r_launch <= 1'b0;
                        r_sl     <= u_quo;
                        r_state  <= S_BAL;
                    end
                end
                S_BAL: begin
                    // boost the lagging wheel, trim the leading one
                    if (r_sr < r_sl) begin
                        r_rs  <= c_rs_up_c;
                        r_rf  <= c_rf_up_c;
                        r_ls  <= c_ls_dn;
                        r_lf  <= c_lf_dn;
                        r_ind <= LED_RED;
                    end else if (r_sl < r_sr) begin
                        r_ls  <= c_ls_up_c;
                        r_lf  <= c_lf_up_c;
                        r_rs  <= c_rs_dn;
                        r_rf  <= c_rf_dn;
                        r_ind <= LED_BLUE;
                    end else begin
                        r_ind <= LED_GREEN;
                    end
                    r_rm    <= r_rc;
                    r_lm    <= r_lc;
                    r_state <= S_DRR;
                end
                S_DRR, S_DRL: begin
                    if (!c_need) begin
                        // at target drop to zero, otherwise hold
                        if (w_ge) begin
                            if (r_state == S_DRR) begin
                                r_rd <= '0;
                            end else begin
                                r_ld <= '0;
                            end
                        end
                        r_state <= (r_state == S_DRR) ? S_DRL : S_FIN;
                    end else if (r_launch && u_done) begin
                        r_launch <= 1'b0;
                        if (r_state == S_DRR) begin
                            r_rd <= w_duty;
                        end else begin
                            r_ld <= w_duty;
                        end
                        r_state <= (r_state == S_DRR) ? S_DRL : S_FIN;
                    end
                end
                S_FIN: begin
                    r_moving <= (r_rc < r_rt) || (r_lc < r_lt);
                    r_fin    <= 1'b0;
                    if (!((r_rc < r_rt) || (r_lc < r_lt))) begin
                        r_fin    <= 1'b1;
                        r_active <= 1'b0;
                        r_rd     <= '0;
                        r_ld     <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_out_valid || i_out_ready)) begin
            r_out.left_duty  <= 10'(r_ld);
            r_out.right_duty <= 10'(r_rd);
            r_out.led_color  <= r_ind;
            r_out.moving     <= r_moving;
            r_out.finished   <= r_fin;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/core/esmp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esmp_checker
// Port-level checks of the synced move profile block.
// ----------------------------------------------------------------------------
`include "encoder_synced_move_profile_top_macros.svh"

module esmp_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  esmp_pkg::t_out_item o_out
);
    import esmp_pkg::*;

    `ESMP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))
    `ESMP_ASSERT_NOW(a_fin_stops, i_clk, i_rst_n, o_out_valid && o_out.finished, !o_out.moving)
    `ESMP_ASSERT_NOW(a_fin_zero, i_clk, i_rst_n, o_out_valid && o_out.finished, (o_out.left_duty == 10'd0) && (o_out.right_duty == 10'd0))
    `ESMP_ASSERT_NOW(a_led_code, i_clk, i_rst_n, o_out_valid, (o_out.led_color == LED_GREEN) || (o_out.led_color == LED_RED) || (o_out.led_color == LED_BLUE))

endmodule

bind encoder_synced_move_profile_top esmp_checker u_esmp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Synced move profile testbench
// Drives start and encoder-pulse transfers into the two-wheel move controller,
// predicts each result with a local model of the duty profile and balance
// logic, and checks every output transfer against it in order.
// ----------------------------------------------------------------------------
module tb;
    import esmp_pkg::*;

    localparam int DUTY_MAX  = 1000;
    localparam int COUNT_MAX = 65535;

    // Predicts duty, indicator and completion of a move, and holds the results
    // still owed by the block.
    class move_profile_board;
        int unsigned fast_ramp, slow_ramp, sync_int, corr_step;
        int unsigned init_inc, init_min, left_scale;
        int unsigned r_cnt, l_cnt, r_mark, l_mark, r_tgt, l_tgt;
        int unsigned r_span, r_floor, l_span, l_floor, r_drive, l_drive;
        logic [1:0] led;
        bit running;
        t_out_item owed[$];
        int errors;

        function void set_defaults();
            fast_ramp = 200; slow_ramp = 500; sync_int = 50; corr_step = 5;
            init_inc = 500; init_min = 150; left_scale = 998;
            r_cnt = 0; l_cnt = 0; r_mark = 0; l_mark = 0; r_tgt = 0; l_tgt = 0;
            r_span = 0; r_floor = 0; l_span = 0; l_floor = 0;
            r_drive = 0; l_drive = 0; led = LED_GREEN; running = 0; errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
            case (idx)
                REG_FAST_RAMP:  fast_ramp = v & 16'hFFFF;
                REG_SLOW_RAMP:  slow_ramp = v & 16'hFFFF;
                REG_SYNC_INT:   sync_int = v & 16'hFFFF;
                REG_CORR_STEP:  corr_step = v & 8'hFF;
                REG_INIT_INC:   init_inc = v & 10'h3FF;
                REG_INIT_MIN:   init_min = v & 10'h3FF;
                REG_LEFT_SCALE: left_scale = v & 10'h3FF;
                default: ;
            endcase
        endfunction

        function int unsigned sat(longint unsigned v);
            return (v > DUTY_MAX) ? DUTY_MAX : int'(v);
        endfunction

        function int unsigned covered(int unsigned c, int unsigned m, int unsigned t);
            if (t == 0) return PERMILLE;
            return (PERMILLE * ((c >= m) ? c - m : 0)) / t;
        endfunction

        function int unsigned next_duty(int unsigned c, int unsigned t, int unsigned span,
                                        int unsigned flr, int unsigned held);
            longint unsigned f, s;
            f = (fast_ramp == 0) ? 1 : fast_ramp;
            s = (slow_ramp == 0) ? 1 : slow_ramp;
            if (c >= t) return 0;
            if (c <= fast_ramp) return sat(flr + (longint'(span) * c) / f);
            if (t - c <= slow_ramp) return sat(flr + (longint'(span) * (t - c)) / s);
            return held;
        endfunction

        // Note an accepted input transfer and queue the result it causes.
        function void note_input(t_in_item it);
            t_out_item r;
            bit step, mv, fin;
            int unsigned sr, sl;
            longint unsigned lt;
            step = 0; mv = 0; fin = 0;
            if (it.kind == KIND_START) begin
                r_tgt = 32'(it.distance);
                lt = (longint'(it.distance) * left_scale) / PERMILLE;
                l_tgt = (lt > COUNT_MAX) ? COUNT_MAX : 32'(lt);
                r_cnt = 0; l_cnt = 0; r_mark = 0; l_mark = 0;
                r_span = sat(init_inc); l_span = r_span;
                r_floor = sat(init_min); l_floor = r_floor;
                r_drive = 0; l_drive = 0; running = 1; step = 1;
            end else if (running) begin
                if (it.left_pulse && l_cnt < COUNT_MAX) l_cnt++;
                if (it.right_pulse && r_cnt < COUNT_MAX) r_cnt++;
                if (r_cnt - r_mark > sync_int || l_cnt - l_mark > sync_int) begin
                    sr = covered(r_cnt, r_mark, r_tgt);
                    sl = covered(l_cnt, l_mark, l_tgt);
                    if (sr < sl) begin
                        r_span = sat(r_span + corr_step); r_floor = sat(r_floor + corr_step);
                        l_span = (l_span > corr_step) ? l_span - corr_step : 0;
                        l_floor = (l_floor > corr_step) ? l_floor - corr_step : 0;
                        led = LED_RED;
                    end else if (sl < sr) begin
                        l_span = sat(l_span + corr_step); l_floor = sat(l_floor + corr_step);
                        r_span = (r_span > corr_step) ? r_span - corr_step : 0;
                        r_floor = (r_floor > corr_step) ? r_floor - corr_step : 0;
                        led = LED_BLUE;
                    end else begin
                        led = LED_GREEN;
                    end
                    r_mark = r_cnt; l_mark = l_cnt;
                end
                step = 1;
            end
            if (step) begin
                r_drive = next_duty(r_cnt, r_tgt, r_span, r_floor, r_drive);
                l_drive = next_duty(l_cnt, l_tgt, l_span, l_floor, l_drive);
                mv = (r_cnt < r_tgt) || (l_cnt < l_tgt);
                if (!mv) begin
                    fin = 1; running = 0; r_drive = 0; l_drive = 0;
                end
            end
            r.left_duty = l_drive[9:0];
            r.right_duty = r_drive[9:0];
            r.led_color = led;
            r.moving = mv;
            r.finished = fin;
            owed.push_back(r);
        endfunction

        // Compare a result transfer with the oldest owed result.
        function void check_result(t_out_item got);
            t_out_item want;
            if (owed.size() == 0) begin
                $display("%0t unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.left_duty !== want.left_duty)
                $display("%0t left_duty exp %0d got %0d", $time, want.left_duty, got.left_duty);
            if (got.right_duty !== want.right_duty)
                $display("%0t right_duty exp %0d got %0d", $time, want.right_duty,
                         got.right_duty);
            if (got.led_color !== want.led_color)
                $display("%0t led_color exp %0d got %0d", $time, want.led_color, got.led_color);
            if (got.moving !== want.moving)
                $display("%0t moving exp %0d got %0d", $time, want.moving, got.moving);
            if (got.finished !== want.finished)
                $display("%0t finished exp %0d got %0d", $time, want.finished, got.finished);
            if (got !== want) errors++;
        endfunction
    endclass

    logic                  clk, rst_n;
    logic                  in_valid, in_ready, out_valid, out_ready;
    t_in_item              in_item;
    t_out_item             out_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    move_profile_board board;
    int  send_idle_pct, recv_idle_pct;
    bit  hold_off;

    encoder_synced_move_profile_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Hard limit on run time; slowest run is far below this.
    initial begin
        #60ms;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: sample on the rising edge, change ready on the falling edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            board.check_result(out_item);
        end
    end

    initial begin
        out_ready = 0;
        @(negedge clk);
        forever begin
            if (hold_off) begin
                // Hold ready low so the block fills and stalls its input.
                out_ready <= 0;
                repeat (400) @(negedge clk);
                hold_off = 0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            @(negedge clk);
        end
    end

    // Offer one transfer; hold it until accepted at a rising edge. Valid stays
    // up after the transfer until an idle cycle or drain drops it, or the next offer replaces the item.
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_item <= it;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_input(it);
        @(negedge clk);
    endtask

    task automatic send_start(int unsigned move_len);
        t_in_item it;
        it = '0;
        it.kind = KIND_START;
        it.distance = 16'(move_len);
        it.left_pulse = 1'($urandom_range(1));
        it.right_pulse = 1'($urandom_range(1));
        send_item(it);
    endtask

    task automatic send_pulse(bit lp, bit rp);
        t_in_item it;
        it.kind = KIND_PULSE;
        it.distance = 16'($urandom);
        it.left_pulse = lp;
        it.right_pulse = rp;
        send_item(it);
    endtask

    // Drain all owed results, then let any in-flight work settle.
    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 0;
        while (board.owed.size() != 0 && guard < 200000) begin
            @(negedge clk);
            guard++;
        end
        repeat (200) @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_wdata <= CFG_DATA_W'(v);
        board.write_reg(idx, v);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // Run one move with mostly matched pulses and some skew.
    task automatic run_move(int unsigned move_len, int unsigned extra);
        int n;
        send_start(move_len);
        n = move_len + extra;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0:       send_pulse(1, 0);
                1:       send_pulse(0, 1);
                2:       send_pulse(0, 0);
                default: send_pulse(1, 1);
            endcase
        end
    endtask

    task automatic random_phase(int items);
        int sent;
        int unsigned d;
        sent = 0;
        while (sent < items) begin
            d = ($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(120);
            if (d > 300) begin
                // Long target: partial move, restarted later.
                run_move(0, 40);
                sent += 41;
                send_start(d);
                for (int k = 0; k < 60; k++)
                    send_pulse(1'($urandom_range(1)), 1'($urandom_range(1)));
                sent += 61;
            end else begin
                run_move(d, $urandom_range(8));
                sent += d + 5;
            end
            if ($urandom_range(9) == 0) begin
                send_pulse(1'($urandom_range(1)), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    task automatic set_regs(int unsigned f, int unsigned s, int unsigned y,
                            int unsigned c, int unsigned i, int unsigned m,
                            int unsigned l);
        write_cfg(REG_FAST_RAMP, f);
        write_cfg(REG_SLOW_RAMP, s);
        write_cfg(REG_SYNC_INT, y);
        write_cfg(REG_CORR_STEP, c);
        write_cfg(REG_INIT_INC, i);
        write_cfg(REG_INIT_MIN, m);
        write_cfg(REG_LEFT_SCALE, l);
    endtask

    initial begin
        board = new();
        board.set_defaults();
        rst_n = 0;
        in_valid = 0;
        in_item = '0;
        cfg_we = 0;
        cfg_idx = REG_FAST_RAMP;
        cfg_wdata = '0;
        hold_off = 0;
        send_idle_pct = 28;
        recv_idle_pct = 65;
        repeat (12) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: pulses while idle, zero distance, maximum distance, restart.
        send_pulse(1, 1);
        send_start(0);
        send_pulse(1, 0);
        send_start(65535);
        send_pulse(1, 1);
        send_pulse(0, 1);
        send_start(3);
        for (int k = 0; k < 4; k++) send_pulse(1, 1);
        send_pulse(1, 1);
        drain();

        // Tiny ramps and zero sync interval: balance check on every tick.
        set_regs(0, 0, 0, 255, 1000, 1000, 1000);
        run_move(6, 2);
        run_move(5, 0);
        drain();
        set_regs(65535, 65535, 65535, 0, 0, 0, 0);
        run_move(4, 1);
        drain();
        // Stall the receiver while inputs keep coming.
        set_regs(3, 4, 2, 7, 600, 200, 500);
        hold_off = 1;
        run_move(40, 4);
        random_phase(600);
        drain();

        send_idle_pct = 65;
        recv_idle_pct = 28;
        set_regs(10, 20, 5, 40, 900, 900, 999);
        random_phase(600);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(200, 500, 50, 5, 500, 150, 998);
        random_phase(700);
        drain();

        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
